[src/gtfp_pkg.sv]
// Shared types, constants and helper functions for the trace frame parser.
package gtfp_pkg;

	localparam int unsigned NumFields = 5;
	localparam int unsigned MarkLen   = 7;

	localparam logic [7:0] ChDollar = 8'h24;
	localparam logic [7:0] ChCr     = 8'h0d;
	localparam logic [7:0] ChSpace  = 8'h20;
	localparam logic [7:0] ChUnder  = 8'h5f;
	localparam logic [7:0] ChZero   = 8'h30;

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_SKIP    = 2'd2,
		PH_PAYLOAD = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_HEADER  = 2'd1,
		KIND_BAD     = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic        last_byte;
		logic [15:0] trace_length;
		logic [15:0] part_index;
		logic [15:0] part_total;
		logic [15:0] sample_number;
		logic [15:0] stack_number;
	} res_t;

	function automatic logic [7:0] mark_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = 8'h74; // t
			3'd1: c = 8'h72; // r
			3'd2: c = 8'h61; // a
			3'd3: c = 8'h63; // c
			3'd4: c = 8'h65; // e
			3'd5: c = 8'h20; // space
			3'd6: c = 8'h2b; // +
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] field_end(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd1, 3'd3: c = ChUnder;
			default: c = ChSpace;
		endcase
		return c;
	endfunction

endpackage

[src/gtfp_in_if.sv]
// Byte input channel: valid/ready handshake with one received byte.
interface gtfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

[src/gtfp_out_if.sv]
// Result channel: valid/ready handshake with payload or header fields.
interface gtfp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  payload_byte;
	logic        last_byte;
	logic [15:0] trace_length;
	logic [15:0] part_index;
	logic [15:0] part_total;
	logic [15:0] sample_number;
	logic [15:0] stack_number;

	modport source (output valid, output kind, output payload_byte, output last_byte,
		output trace_length, output part_index, output part_total,
		output sample_number, output stack_number, input ready);
	modport sink (input valid, input kind, input payload_byte, input last_byte,
		input trace_length, input part_index, input part_total,
		input sample_number, input stack_number, output ready);
endinterface

[src/gtfp_core.sv]
// Parser state and per-byte next-state / result logic.
module gtfp_core
	import gtfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	output logic       emit,
	output res_t       res
);

	phase_t      phase_q, phase_d;
	logic [2:0]  hpos_q, hpos_d;
	logic        mark_ok_q, mark_ok_d;
	logic [2:0]  fidx_q, fidx_d;
	logic [15:0] acc_q, acc_d;
	logic [15:0] fields_q [NumFields];
	logic [15:0] fields_d [NumFields];
	logic [15:0] remain_q, remain_d;
	logic [15:0] acc_mul;
	logic [15:0] hdr_val [NumFields];

	assign acc_mul = {acc_q[12:0], 3'b000} + {acc_q[14:0], 1'b0}
		+ {8'h00, rx_byte} - {8'h00, ChZero};

	always_comb begin
		for (int k = 0; k < NumFields; k++) begin
			hdr_val[k] = (fidx_q == 3'(k)) ? acc_q : fields_q[k];
		end
	end

	always_comb begin
		phase_d   = phase_q;
		hpos_d    = hpos_q;
		mark_ok_d = mark_ok_q;
		fidx_d    = fidx_q;
		acc_d     = acc_q;
		remain_d  = remain_q;
		for (int k = 0; k < NumFields; k++) begin
			fields_d[k] = fields_q[k];
		end
		emit              = 1'b0;
		res               = '0;
		res.kind          = KIND_PAYLOAD;
		case (phase_q)
			PH_HUNT: begin
				if (rx_byte == ChDollar) begin
					hpos_d    = '0;
					mark_ok_d = 1'b1;
					fidx_d    = '0;
					acc_d     = '0;
					for (int k = 0; k < NumFields; k++) begin
						fields_d[k] = '0;
					end
					phase_d = PH_HEADER;
				end
			end
			PH_HEADER: begin
				if (rx_byte != ChCr) begin
					if (hpos_q < 3'(MarkLen)) begin
						if (rx_byte != mark_char(hpos_q)) begin
							mark_ok_d = 1'b0;
						end
					end else if (fidx_q < 3'(NumFields)) begin
						if (rx_byte == field_end(fidx_q)) begin
							for (int k = 0; k < NumFields; k++) begin
								if (fidx_q == 3'(k)) begin
									fields_d[k] = acc_q;
								end
							end
							fidx_d = fidx_q + 3'd1;
							acc_d  = '0;
						end else begin
							acc_d = acc_mul;
						end
					end
					if (hpos_q != 3'd7) begin
						hpos_d = hpos_q + 3'd1;
					end
				end else begin
					emit = 1'b1;
					if (hpos_q < 3'(MarkLen) || !mark_ok_q) begin
						res.kind = KIND_BAD;
						phase_d  = PH_HUNT;
					end else begin
						res.kind          = KIND_HEADER;
						res.trace_length  = hdr_val[0];
						res.part_index    = hdr_val[1];
						res.part_total    = hdr_val[2];
						res.sample_number = hdr_val[3];
						res.stack_number  = hdr_val[4];
						for (int k = 0; k < NumFields; k++) begin
							fields_d[k] = hdr_val[k];
						end
						remain_d = hdr_val[0];
						phase_d  = PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				phase_d = (remain_q == '0) ? PH_HUNT : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				emit             = 1'b1;
				res.kind         = KIND_PAYLOAD;
				res.payload_byte = rx_byte;
				res.last_byte    = (remain_q <= 16'd1);
				if (remain_q <= 16'd1) begin
					remain_d = '0;
					phase_d  = PH_HUNT;
				end else begin
					remain_d = remain_q - 16'd1;
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			hpos_q    <= '0;
			mark_ok_q <= 1'b1;
			fidx_q    <= '0;
			acc_q     <= '0;
			remain_q  <= '0;
			for (int k = 0; k < NumFields; k++) begin
				fields_q[k] <= '0;
			end
		end else if (step) begin
			phase_q   <= phase_d;
			hpos_q    <= hpos_d;
			mark_ok_q <= mark_ok_d;
			fidx_q    <= fidx_d;
			acc_q     <= acc_d;
			remain_q  <= remain_d;
			for (int k = 0; k < NumFields; k++) begin
				fields_q[k] <= fields_d[k];
			end
		end
	end

endmodule

[src/gtfp_out_reg.sv]
// Result register driving the output channel.
module gtfp_out_reg
	import gtfp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  res_t         res,
	output logic         free,
	gtfp_out_if.source   dout
);

	logic full_q;
	res_t res_q;

	assign free = !full_q || dout.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (load) begin
			full_q <= 1'b1;
		end else if (dout.ready) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign dout.valid         = full_q;
	assign dout.kind          = res_q.kind;
	assign dout.payload_byte  = res_q.payload_byte;
	assign dout.last_byte     = res_q.last_byte;
	assign dout.trace_length  = res_q.trace_length;
	assign dout.part_index    = res_q.part_index;
	assign dout.part_total    = res_q.part_total;
	assign dout.sample_number = res_q.sample_number;
	assign dout.stack_number  = res_q.stack_number;

endmodule

[src/gpr_trace_frame_parser.sv]
// Top level of the trace frame parser: input stage, parser core, result register.
//
//   channel  dir  beat contents
//   din      in   rx_byte (8)
//   dout     out  kind (2), payload_byte (8), last_byte, five 16-bit header fields
//
// One byte per cycle unless dout stalls; a byte is registered in both stages.
// Reset clears parser state to hunting for '$' and empties both stages.
// A stalled dout only blocks bytes that produce a beat; the input stage still
// fills while the result register waits.
module gpr_trace_frame_parser
	import gtfp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	gtfp_in_if.sink   din,
	gtfp_out_if.source dout
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       emit;
	logic       free;
	logic       adv;
	logic       step;
	res_t       res;

	assign adv       = free || !emit;
	assign step      = valid_s1 && adv;
	assign din.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			byte_s1 <= din.rx_byte;
		end
	end

	gtfp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.emit    (emit),
		.res     (res)
	);

	gtfp_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step && emit),
		.res    (res),
		.free   (free),
		.dout   (dout)
	);

endmodule
